// ----- sv/sbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants for the scalar blend colormap block
// Color stop table, register indexes, fixed field widths, pipeline tags.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int WEIGHT_BITS    = 16;
   localparam int COLOR_BITS     = 8;

   localparam int STOP_COUNT     = 9;
   localparam int POS_BITS       = 17;   // Q0.16 with room for 1.0
   localparam int QUO_BITS       = 16;   // fraction bits from each divider
   localparam int SEG_BITS       = 15;   // widest segment span fits here
   localparam int SEG_IDX_BITS   = $clog2(STOP_COUNT);

   localparam logic [POS_BITS-1:0]   ONE_Q16     = 17'h10000;
   localparam logic [POS_BITS:0]     SMOOTH_K    = 18'd196608;   // 3.0 in Q16
   localparam logic [COLOR_BITS-1:0] ALPHA_VALUE = 8'hff;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCALAR_LOW    = 4'd0,
      CSR_SCALAR_HIGH   = 4'd1,
      CSR_WEIGHT_FIRST  = 4'd2,
      CSR_WEIGHT_SECOND = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   pos;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } stop_type;

   localparam stop_type STOP_TABLE [STOP_COUNT] = '{
      '{17'd0,     8'h80, 8'h00, 8'hc0},
      '{17'd6554,  8'h40, 8'h30, 8'hff},
      '{17'd13107, 8'h00, 8'h90, 8'hfa},
      '{17'd19661, 8'h00, 8'hd8, 8'hb0},
      '{17'd26214, 8'h10, 8'hbb, 8'h20},
      '{17'd32768, 8'h90, 8'hd0, 8'h00},
      '{17'd39322, 8'hf0, 8'hd0, 8'h00},
      '{17'd45875, 8'hf0, 8'h70, 8'h00},
      '{17'd65536, 8'hff, 8'h00, 8'h00}
   };

   // clamp result of the normalize step, rides along the first divider
   typedef struct packed {
      logic one;
      logic zero;
   } clamp_type;

   // segment tag, rides along the second divider
   typedef struct packed {
      logic                    full;   // fraction is exactly 1.0
      logic [SEG_IDX_BITS-1:0] seg;    // index of the lower stop
   } seg_tag_type;

endpackage

// ----- sv/sbc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_if: channel interfaces of the scalar blend colormap block
// Pixel request, colored pixel response and register write channels.
// ----------------------------------------------------------------------------
interface sbc_req_if #(parameter int SCALAR_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SCALAR_BITS-1:0] sample_first;
   logic signed [SCALAR_BITS-1:0] sample_second;

   modport source (output valid, sample_first, sample_second, input ready);
   modport sink   (input valid, sample_first, sample_second, output ready);
endinterface

interface sbc_rsp_if;
   import sbc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;
   logic [COLOR_BITS-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface sbc_csr_if;
   import sbc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/sbc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_div: pipelined restoring fraction divider
// Computes floor(rem * 2^STEPS / den) for rem < den, one quotient bit per
// stage, with a sideband tag and per-stage valid/ready flow control.
// ----------------------------------------------------------------------------
module sbc_div #(
   parameter int WIDTH    = 15,
   parameter int PAY_BITS = 1,
   parameter int STEPS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [WIDTH-1:0]    in_rem,
   input  logic [WIDTH-1:0]    in_den,
   input  logic [PAY_BITS-1:0] in_pay,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [STEPS-1:0]    out_quo,
   output logic [PAY_BITS-1:0] out_pay
);
   logic                valid_ff [STEPS];
   logic                stage_ready [STEPS];
   logic [WIDTH-1:0]    rem_ff [STEPS];
   logic [WIDTH-1:0]    den_ff [STEPS];
   logic [STEPS-1:0]    quo_ff [STEPS];
   logic [PAY_BITS-1:0] pay_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                valid_src;
      logic [WIDTH-1:0]    rem_src;
      logic [WIDTH-1:0]    den_src;
      logic [STEPS-1:0]    quo_src;
      logic [PAY_BITS-1:0] pay_src;
      logic [WIDTH:0]      shifted;
      logic [WIDTH:0]      diff;
      logic                take;
      logic [WIDTH-1:0]    rem_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_rem;
         assign den_src   = in_den;
         assign quo_src   = '0;
         assign pay_src   = in_pay;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign pay_src   = pay_ff[k-1];
      end

      if (k == STEPS-1) begin : g_last
         assign stage_ready[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end

      assign shifted = {rem_src, 1'b0};
      assign diff    = shifted - {1'b0, den_src};
      assign take    = shifted >= {1'b0, den_src};
      assign rem_in  = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= {quo_src[STEPS-2:0], take};
            pay_ff[k] <= pay_src;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

   // partial remainder never reaches the divisor when fed rem < den
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[STEPS-1] |-> rem_ff[STEPS-1] < den_ff[STEPS-1])
      else $error("divider remainder not below divisor");

   // a stalled output holds its quotient and tag
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_quo) && $stable(out_pay))
      else $error("divider output changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> valid_ff[0])
      else $error("divider input stalled with first stage empty");

endmodule

// ----- sv/scalar_blend_colormap_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_blend_colormap_pixel: two-sample blend and nine-stop colormap
// Blends two scalar samples with per-frame weights, normalizes them into the
// configured range and maps the result to an RGBA pixel with smoothstep.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one pixel per request: sample_first, sample_second (signed Q8.8
//          at the default width). Taken when valid and ready are both high.
//   rsp  - one colored pixel per request, in order; alpha is always 255.
//   csr  - register writes (index, data), always ready. Write registers only
//          while no request is in flight.
// Throughput: one pixel per clock while rsp.ready stays high. Every stage is registered and
//   the two 16-step fraction dividers retire one quotient bit per stage.
// Pipeline: a request passes 5 normalize stages, 16 divider stages, segment
//   select, 16 divider stages, then 4 smoothstep and blend stages.
// Reset: clears all valid bits and loads register defaults (low 0, high 1.0,
//   weights 0 and 0xffff). Derived range terms settle in the cycle after a write lands.
// Stall: each stage holds while the stage after it is full and stalled, so
//   bubbles close up and req.ready drops only once the whole pipe is full.
// ----------------------------------------------------------------------------
module scalar_blend_colormap_pixel #(
   parameter int SCALAR_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   sbc_req_if.sink    req,
   sbc_rsp_if.source  rsp,
   sbc_csr_if.sink    csr
);
   import sbc_pkg::*;

   localparam int PROD_BITS  = SCALAR_BITS + WEIGHT_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int NUM_BITS   = SUM_BITS + 1;
   localparam int RANGE_BITS = SCALAR_BITS + 1;
   localparam int DEN_BITS   = RANGE_BITS + WEIGHT_BITS + 1;
   localparam int SQ_BITS    = 2 * POS_BITS;
   localparam int CUBE_BITS  = SQ_BITS + POS_BITS + 1;
   localparam int BLEND_BITS = POS_BITS + COLOR_BITS + 2;

   // ---------------- registers ----------------
   logic signed [SCALAR_BITS-1:0] scalar_low_ff;
   logic signed [SCALAR_BITS-1:0] scalar_high_ff;
   logic [WEIGHT_BITS-1:0]        weight_first_ff;
   logic [WEIGHT_BITS-1:0]        weight_second_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scalar_low_ff    <= '0;
         scalar_high_ff   <= SCALAR_BITS'(256);
         weight_first_ff  <= '0;
         weight_second_ff <= 16'hffff;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SCALAR_LOW:    scalar_low_ff    <= csr.data[SCALAR_BITS-1:0];
            CSR_SCALAR_HIGH:   scalar_high_ff   <= csr.data[SCALAR_BITS-1:0];
            CSR_WEIGHT_FIRST:  weight_first_ff  <= csr.data[WEIGHT_BITS-1:0];
            CSR_WEIGHT_SECOND: weight_second_ff <= csr.data[WEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame-constant terms: low*W and |W*R|, with the sign of R folded into
   // the numerator later. With both weights zero the blend is 0, so the
   // numerator reduces to -low over the bare range.
   logic [WEIGHT_BITS:0]           wsum_in;
   logic                           wzero_in;
   logic signed [RANGE_BITS-1:0]   range_in;
   logic [RANGE_BITS-1:0]          range_mag_in;
   logic [DEN_BITS-1:0]            den_prod_in;
   logic [DEN_BITS-1:0]            den_in;
   logic signed [SUM_BITS-1:0]     low_prod_in;
   logic signed [SUM_BITS-1:0]     low_w_in;
   logic [DEN_BITS-1:0]            den_ff;
   logic                           den_neg_ff;
   logic signed [SUM_BITS-1:0]     low_w_ff;

   assign wsum_in      = {1'b0, weight_first_ff} + {1'b0, weight_second_ff};
   assign wzero_in     = (wsum_in == '0);
   assign range_in     = RANGE_BITS'(scalar_high_ff) - RANGE_BITS'(scalar_low_ff);
   assign range_mag_in = (range_in == '0)        ? RANGE_BITS'(256) :
                         range_in[RANGE_BITS-1]  ? RANGE_BITS'(-range_in) :
                                                   RANGE_BITS'(range_in);
   assign den_prod_in  = wsum_in * range_mag_in;
   assign den_in       = wzero_in ? DEN_BITS'(range_mag_in) : den_prod_in;
   assign low_prod_in  = scalar_low_ff * $signed({1'b0, wsum_in});
   assign low_w_in     = wzero_in ? SUM_BITS'(scalar_low_ff) : low_prod_in;

   always_ff @(posedge clock) begin
      den_ff     <= den_in;
      den_neg_ff <= range_in[RANGE_BITS-1];
      low_w_ff   <= low_w_in;
   end

   // ---------------- pipeline flow control ----------------
   logic [10:1] valid_ff;
   logic [10:1] ready;
   logic        div1_in_ready;
   logic        div1_out_valid;
   logic        div2_in_ready;
   logic        div2_out_valid;

   assign ready[10] = !valid_ff[10] || rsp.ready;
   assign ready[9]  = !valid_ff[9]  || ready[10];
   assign ready[8]  = !valid_ff[8]  || ready[9];
   assign ready[7]  = !valid_ff[7]  || ready[8];
   assign ready[6]  = !valid_ff[6]  || div2_in_ready;
   assign ready[5]  = !valid_ff[5]  || div1_in_ready;
   assign ready[4]  = !valid_ff[4]  || ready[5];
   assign ready[3]  = !valid_ff[3]  || ready[4];
   assign ready[2]  = !valid_ff[2]  || ready[3];
   assign ready[1]  = !valid_ff[1]  || ready[2];
   assign req.ready = ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[1])  valid_ff[1]  <= req.valid;
         if (ready[2])  valid_ff[2]  <= valid_ff[1];
         if (ready[3])  valid_ff[3]  <= valid_ff[2];
         if (ready[4])  valid_ff[4]  <= valid_ff[3];
         if (ready[5])  valid_ff[5]  <= valid_ff[4];
         if (ready[6])  valid_ff[6]  <= div1_out_valid;
         if (ready[7])  valid_ff[7]  <= div2_out_valid;
         if (ready[8])  valid_ff[8]  <= valid_ff[7];
         if (ready[9])  valid_ff[9]  <= valid_ff[8];
         if (ready[10]) valid_ff[10] <= valid_ff[9];
      end
   end

   // ---------------- stages 1-5: blend and normalize ----------------
   logic signed [SCALAR_BITS-1:0] first_ff;
   logic signed [SCALAR_BITS-1:0] second_ff;
   logic signed [PROD_BITS-1:0]   prod_first_in;
   logic signed [PROD_BITS-1:0]   prod_second_in;
   logic signed [PROD_BITS-1:0]   prod_first_ff;
   logic signed [PROD_BITS-1:0]   prod_second_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic signed [NUM_BITS-1:0]    num_ff;
   clamp_type                     clamp_in;
   clamp_type                     clamp_ff;
   logic [DEN_BITS-1:0]           rem_ff;

   assign prod_first_in  = first_ff  * $signed({1'b0, weight_first_ff});
   assign prod_second_in = second_ff * $signed({1'b0, weight_second_ff});

   // numerator <= 0 clamps to zero, numerator >= denominator clamps to one
   assign clamp_in.zero = num_ff[NUM_BITS-1] || (num_ff == '0);
   assign clamp_in.one  = (num_ff >= $signed({1'b0, den_ff}));

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         first_ff  <= req.sample_first;
         second_ff <= req.sample_second;
      end
      if (ready[2]) begin
         prod_first_ff  <= prod_first_in;
         prod_second_ff <= prod_second_in;
      end
      if (ready[3]) begin
         sum_ff <= SUM_BITS'(prod_first_ff) + SUM_BITS'(prod_second_ff);
      end
      if (ready[4]) begin
         num_ff <= den_neg_ff ? NUM_BITS'(low_w_ff) - NUM_BITS'(sum_ff)
                              : NUM_BITS'(sum_ff) - NUM_BITS'(low_w_ff);
      end
      if (ready[5]) begin
         clamp_ff <= clamp_in;
         rem_ff   <= (clamp_in.zero || clamp_in.one) ? '0 : num_ff[DEN_BITS-1:0];
      end
   end

   // ---------------- normalize divider ----------------
   logic [QUO_BITS-1:0] norm_quo;
   clamp_type           norm_clamp;

   sbc_div #(
      .WIDTH    (DEN_BITS),
      .PAY_BITS ($bits(clamp_type)),
      .STEPS    (QUO_BITS)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[5]),
      .in_ready  (div1_in_ready),
      .in_rem    (rem_ff),
      .in_den    (den_ff),
      .in_pay    (clamp_ff),
      .out_valid (div1_out_valid),
      .out_ready (ready[6]),
      .out_quo   (norm_quo),
      .out_pay   (norm_clamp)
   );

   // ---------------- stage 6: segment select ----------------
   logic [POS_BITS-1:0]     value_in;
   logic [SEG_IDX_BITS-1:0] seg_lo_in;
   logic [SEG_IDX_BITS-1:0] seg_hi_in;
   logic [POS_BITS-1:0]     offset_in;
   logic [POS_BITS-1:0]     span_in;
   seg_tag_type             tag_in;
   seg_tag_type             tag_ff;
   logic [SEG_BITS-1:0]     seg_rem_ff;
   logic [SEG_BITS-1:0]     seg_den_ff;

   assign value_in = norm_clamp.one  ? ONE_Q16 :
                     norm_clamp.zero ? '0 : {1'b0, norm_quo};

   // first stop at or above the value closes the segment
   always_comb begin
      seg_lo_in = SEG_IDX_BITS'(STOP_COUNT - 2);
      for (int i = STOP_COUNT - 1; i >= 1; i--) begin
         if (value_in <= STOP_TABLE[i].pos) seg_lo_in = SEG_IDX_BITS'(i - 1);
      end
   end

   assign seg_hi_in  = seg_lo_in + 1'b1;
   assign offset_in  = value_in - STOP_TABLE[seg_lo_in].pos;
   assign span_in    = STOP_TABLE[seg_hi_in].pos - STOP_TABLE[seg_lo_in].pos;
   assign tag_in.seg = seg_lo_in;
   assign tag_in.full = (offset_in == span_in);

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         tag_ff     <= tag_in;
         seg_rem_ff <= tag_in.full ? '0 : offset_in[SEG_BITS-1:0];
         seg_den_ff <= span_in[SEG_BITS-1:0];
      end
   end

   // ---------------- fraction divider ----------------
   logic [QUO_BITS-1:0] frac_quo;
   seg_tag_type         frac_tag;

   sbc_div #(
      .WIDTH    (SEG_BITS),
      .PAY_BITS ($bits(seg_tag_type)),
      .STEPS    (QUO_BITS)
   ) u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[6]),
      .in_ready  (div2_in_ready),
      .in_rem    (seg_rem_ff),
      .in_den    (seg_den_ff),
      .in_pay    (tag_ff),
      .out_valid (div2_out_valid),
      .out_ready (ready[7]),
      .out_quo   (frac_quo),
      .out_pay   (frac_tag)
   );

   // ---------------- stages 7-10: smoothstep and blend ----------------
   logic [POS_BITS-1:0]           frac_in;
   logic [SQ_BITS-1:0]            frac_sq_ff;
   logic [POS_BITS:0]             cubic_k_ff;
   logic [SEG_IDX_BITS-1:0]       seg7_ff;
   logic [CUBE_BITS-1:0]          cube_in;
   logic [POS_BITS-1:0]           smooth_ff;
   logic [SEG_IDX_BITS-1:0]       seg8_ff;
   logic [SEG_IDX_BITS-1:0]       seg_next8;
   logic signed [COLOR_BITS:0]    diff_red_in;
   logic signed [COLOR_BITS:0]    diff_green_in;
   logic signed [COLOR_BITS:0]    diff_blue_in;
   logic signed [BLEND_BITS-1:0]  mul_red_ff;
   logic signed [BLEND_BITS-1:0]  mul_green_ff;
   logic signed [BLEND_BITS-1:0]  mul_blue_ff;
   logic [SEG_IDX_BITS-1:0]       seg9_ff;
   logic signed [BLEND_BITS-1:0]  acc_red_in;
   logic signed [BLEND_BITS-1:0]  acc_green_in;
   logic signed [BLEND_BITS-1:0]  acc_blue_in;
   logic [COLOR_BITS-1:0]         red_ff;
   logic [COLOR_BITS-1:0]         green_ff;
   logic [COLOR_BITS-1:0]         blue_ff;

   assign frac_in = frac_tag.full ? ONE_Q16 : {1'b0, frac_quo};
   assign cube_in = frac_sq_ff * cubic_k_ff;

   assign seg_next8     = seg8_ff + 1'b1;
   assign diff_red_in   = $signed({1'b0, STOP_TABLE[seg_next8].red})
                        - $signed({1'b0, STOP_TABLE[seg8_ff].red});
   assign diff_green_in = $signed({1'b0, STOP_TABLE[seg_next8].green})
                        - $signed({1'b0, STOP_TABLE[seg8_ff].green});
   assign diff_blue_in  = $signed({1'b0, STOP_TABLE[seg_next8].blue})
                        - $signed({1'b0, STOP_TABLE[seg8_ff].blue});

   // c0 * 2^16 + s * (c1 - c0); never negative, channel sits in [23:16]
   assign acc_red_in   = $signed({3'b000, STOP_TABLE[seg9_ff].red,   16'h0000}) + mul_red_ff;
   assign acc_green_in = $signed({3'b000, STOP_TABLE[seg9_ff].green, 16'h0000}) + mul_green_ff;
   assign acc_blue_in  = $signed({3'b000, STOP_TABLE[seg9_ff].blue,  16'h0000}) + mul_blue_ff;

   always_ff @(posedge clock) begin
      if (ready[7]) begin
         frac_sq_ff <= frac_in * frac_in;
         cubic_k_ff <= SMOOTH_K - {frac_in, 1'b0};
         seg7_ff    <= frac_tag.seg;
      end
      if (ready[8]) begin
         smooth_ff <= cube_in[2*QUO_BITS +: POS_BITS];
         seg8_ff   <= seg7_ff;
      end
      if (ready[9]) begin
         mul_red_ff   <= $signed({1'b0, smooth_ff}) * diff_red_in;
         mul_green_ff <= $signed({1'b0, smooth_ff}) * diff_green_in;
         mul_blue_ff  <= $signed({1'b0, smooth_ff}) * diff_blue_in;
         seg9_ff      <= seg8_ff;
      end
      if (ready[10]) begin
         red_ff   <= acc_red_in[QUO_BITS +: COLOR_BITS];
         green_ff <= acc_green_in[QUO_BITS +: COLOR_BITS];
         blue_ff  <= acc_blue_in[QUO_BITS +: COLOR_BITS];
      end
   end

   assign rsp.valid = valid_ff[10];
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;
   assign rsp.alpha = ALPHA_VALUE;

   // ---------------- checks ----------------
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> !(clamp_ff.zero && clamp_ff.one))
      else $error("normalized value clamped both ways");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> (seg_rem_ff < seg_den_ff))
      else $error("segment offset outside its segment");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[8] |-> (smooth_ff <= ONE_Q16))
      else $error("smoothstep value above one");

endmodule
